FILE: design/lkv_pkg.sv
// Shared constants and types for the LRU key-value cache.
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam int DATA_W  = 32;

	localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;
	localparam logic signed [DATA_W-1:0] PUT_VALUE  = '0;

	typedef enum logic [0:0] {
		FUNC_GET = 1'b0,
		FUNC_PUT = 1'b1
	} func_t;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

FILE: design/lkv_intf.sv
// Request, response and configuration channel interfaces of the LRU key-value cache.
interface lkv_req_if;
	logic                                 valid;
	logic                                 ready;
	lkv_pkg::func_t                       func;
	logic signed [lkv_pkg::DATA_W-1:0]    key;
	logic signed [lkv_pkg::DATA_W-1:0]    value;

	modport source (output valid, func, key, value, input ready);
	modport sink   (input valid, func, key, value, output ready);
endinterface

interface lkv_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 hit;
	logic signed [lkv_pkg::DATA_W-1:0]    read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkv_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [lkv_pkg::CAP_W-1:0]            capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

FILE: design/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
//
//  channel | dir | payload                      | accepted when
//  --------+-----+------------------------------+---------------------
//  req     | in  | func, key, value             | req.valid & req.ready
//  rsp     | out | hit, read_value              | rsp.valid & rsp.ready
//  cfg     | in  | capacity                     | cfg.valid & cfg.ready
//
// Two register stages: the request register, then the response register. Lookup,
// rank update and table write happen in the cycle an item leaves the request register,
// so one item per cycle is sustained while the response side does not stall.
// Reset clears all valid bits, ranks, the occupancy count and sets capacity to 16.
// A stalled response holds the request stage; req.ready drops only when both stages
// are full and rsp.ready is low. cfg.ready is always high.
module lru_key_value_cache (
	input  logic            clk,
	input  logic            arst_n,
	lkv_req_if.sink         req,
	lkv_rsp_if.source       rsp,
	lkv_cfg_if.sink         cfg
);

	localparam int N = lkv_pkg::ENTRIES;

	// Table
	logic signed [lkv_pkg::DATA_W-1:0] key_q   [N];
	logic signed [lkv_pkg::DATA_W-1:0] value_q [N];
	logic [N-1:0]                      valid_q;
	lkv_pkg::idx_t                     rank_q  [N];
	lkv_pkg::cnt_t                     count_q;
	logic [lkv_pkg::CAP_W-1:0]         capacity_q;

	// Request stage
	logic                              valid_s1;
	lkv_pkg::func_t                    func_s1;
	logic signed [lkv_pkg::DATA_W-1:0] key_s1;
	logic signed [lkv_pkg::DATA_W-1:0] value_s1;

	// Response stage
	logic                              valid_s2;
	logic                              hit_s2;
	logic signed [lkv_pkg::DATA_W-1:0] read_value_s2;

	logic                              out_free;
	logic                              adv_s1;
	logic                              req_acc;
	logic [N-1:0]                      match_vec;
	logic [N-1:0]                      victim_vec;
	logic [N-1:0]                      age_vec;
	logic                              hit;
	logic                              is_put;
	logic                              upd;
	logic                              room;
	logic [lkv_pkg::CAP_W-1:0]         cap_min1;
	lkv_pkg::idx_t                     hit_idx;
	lkv_pkg::idx_t                     free_idx;
	lkv_pkg::idx_t                     victim_idx;
	lkv_pkg::idx_t                     slot;
	lkv_pkg::idx_t                     old_rank;
	lkv_pkg::idx_t                     lru_rank;
	logic signed [lkv_pkg::DATA_W-1:0] read_value_d;

	assign out_free  = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid      = valid_s2;
	assign rsp.hit        = hit_s2;
	assign rsp.read_value = read_value_s2;

	assign is_put   = (func_s1 == lkv_pkg::FUNC_PUT);
	assign lru_rank = lkv_pkg::IDX_W'(count_q - lkv_pkg::CNT_W'(1));
	assign cap_min1 = (capacity_q == '0) ? lkv_pkg::CAP_W'(1) : capacity_q;
	assign room     = (lkv_pkg::CMP_W'(count_q) < lkv_pkg::CMP_W'(cap_min1))
		&& (count_q < lkv_pkg::CNT_W'(N));

	always_comb begin
		for (int i = 0; i < N; i++) begin
			match_vec[i]  = valid_q[i] && (key_q[i] == key_s1);
			victim_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
	end

	// Lowest index wins in each search
	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		victim_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit_idx = lkv_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = lkv_pkg::IDX_W'(i);
			end
			if (victim_vec[i]) begin
				victim_idx = lkv_pkg::IDX_W'(i);
			end
		end
	end

	assign hit      = |match_vec;
	assign upd      = hit || is_put;
	assign old_rank = rank_q[hit_idx];
	assign slot     = hit ? hit_idx : (room ? free_idx : victim_idx);

	// Age every valid entry more recent than the promoted one; on insert age all others
	always_comb begin
		for (int i = 0; i < N; i++) begin
			age_vec[i] = upd && valid_q[i] && (lkv_pkg::IDX_W'(i) != slot)
				&& (!hit || (rank_q[i] < old_rank));
		end
	end

	always_comb begin
		if (is_put) begin
			read_value_d = lkv_pkg::PUT_VALUE;
		end else if (hit) begin
			read_value_d = value_q[hit_idx];
		end else begin
			read_value_d = lkv_pkg::MISS_VALUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_q    <= '0;
			count_q    <= '0;
			capacity_q <= lkv_pkg::CAP_W'(16);
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				capacity_q <= cfg.capacity;
			end
			if (req_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1 && upd) begin
				valid_q[slot] <= 1'b1;
				for (int i = 0; i < N; i++) begin
					if (lkv_pkg::IDX_W'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (age_vec[i]) begin
						rank_q[i] <= rank_q[i] + lkv_pkg::IDX_W'(1);
					end
				end
				if (!hit && room) begin
					count_q <= count_q + lkv_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_s1  <= req.func;
			key_s1   <= req.key;
			value_s1 <= req.value;
		end
		if (adv_s1) begin
			hit_s2        <= hit;
			read_value_s2 <= read_value_d;
		end
		if (adv_s1 && is_put) begin
			key_q[slot]   <= key_s1;
			value_q[slot] <= value_s1;
		end
	end

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == lkv_pkg::CNT_W'($countones(valid_q)))
		else $error("occupancy count disagrees with valid bits");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match_vec))
		else $error("key stored in more than one entry");

	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_put && !hit && !room) |-> $onehot(victim_vec))
		else $error("no unique least recent entry on eviction");

	a_room_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> room)
		else $error("empty table reports no room");

	a_get_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !is_put && !hit) |=> (read_value_s2 == lkv_pkg::MISS_VALUE) && !hit_s2)
		else $error("get miss did not return the miss value");

endmodule

FILE: tb/sv/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: directed and random get/put traffic.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 118;
	localparam int GAP_MAX      = 17;

	typedef struct {
		logic                              hit;
		logic signed [lkv_pkg::DATA_W-1:0] read_value;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	lkv_req_if req_ch ();
	lkv_rsp_if rsp_ch ();
	lkv_cfg_if cfg_ch ();

	lru_key_value_cache uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the cache table
	logic [lkv_pkg::DATA_W-1:0] shadow_key   [lkv_pkg::ENTRIES];
	logic [lkv_pkg::DATA_W-1:0] shadow_value [lkv_pkg::ENTRIES];
	bit                         shadow_valid [lkv_pkg::ENTRIES];
	int unsigned                shadow_age   [lkv_pkg::ENTRIES];
	int unsigned                shadow_count;
	logic [lkv_pkg::CAP_W-1:0]  capacity_reg;

	lookup_result_t lookup_answers[$];
	logic [lkv_pkg::DATA_W-1:0] key_pool[$];

	int  failures;
	int  cycle_count;
	int  request_count;
	int  hit_count;
	int  eviction_count;
	int  capacity_writes;
	bit  src_idle;
	bit  snk_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic lookup_result_t cache_lookup(lkv_pkg::func_t op,
			logic [lkv_pkg::DATA_W-1:0] k, logic [lkv_pkg::DATA_W-1:0] v);
		lookup_result_t res;
		int match;
		int slot;
		int unsigned old_age;
		int unsigned worst;
		int unsigned limit;
		match = -1;
		slot = -1;
		worst = 0;
		request_count++;
		for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
			if (match < 0 && shadow_valid[i] && shadow_key[i] == k)
				match = i;
		end
		if (match >= 0) begin
			hit_count++;
			res.hit = 1'b1;
			res.read_value = (op == lkv_pkg::FUNC_GET) ? shadow_value[match]
				: lkv_pkg::PUT_VALUE;
			if (op == lkv_pkg::FUNC_PUT)
				shadow_value[match] = v;
			old_age = shadow_age[match];
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (shadow_valid[i] && i != match && shadow_age[i] < old_age)
					shadow_age[i]++;
			end
			shadow_age[match] = 0;
			return res;
		end
		res.hit = 1'b0;
		if (op == lkv_pkg::FUNC_GET) begin
			res.read_value = lkv_pkg::MISS_VALUE;
			return res;
		end
		res.read_value = lkv_pkg::PUT_VALUE;
		// Saturate the capacity register to 1..ENTRIES
		limit = (capacity_reg == 0) ? 1
			: (capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity_reg;
		if (shadow_count < limit) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (slot < 0 && !shadow_valid[i])
					slot = i;
			end
		end
		if (slot >= 0) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (shadow_valid[i])
					shadow_age[i]++;
			end
			shadow_count++;
		end else begin
			// Replace the oldest entry; occupancy holds even if capacity shrank
			eviction_count++;
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (shadow_valid[i] && (slot < 0 || shadow_age[i] > worst)) begin
					slot = i;
					worst = shadow_age[i];
				end
			end
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (shadow_valid[i] && i != slot)
					shadow_age[i]++;
			end
		end
		shadow_valid[slot] = 1'b1;
		shadow_key[slot] = k;
		shadow_value[slot] = v;
		shadow_age[slot] = 0;
		return res;
	endfunction

	function automatic int draw_gap(bit enabled);
		if (!enabled)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	always @(posedge clk) begin : monitor
		lookup_result_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				capacity_reg = cfg_ch.capacity;
				capacity_writes++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (lookup_answers.size() == 0) begin
					$error("response with nothing outstanding: hit=%0b read_value=%0d",
						rsp_ch.hit, rsp_ch.read_value);
					failures++;
				end else begin
					want = lookup_answers.pop_front();
					if (rsp_ch.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
						failures++;
					end
					if (rsp_ch.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							rsp_ch.read_value);
						failures++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				want = cache_lookup(req_ch.func, req_ch.key, req_ch.value);
				lookup_answers.insert(lookup_answers.size(), want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("lru_key_value_cache test failed");
			$finish;
		end
	end

	// Response side: when snk_idle is set, hold rsp.ready low for a random gap before taking each item
	initial begin : response_sink
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(snk_idle);
			if (gap > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	task automatic send_request(lkv_pkg::func_t op, logic [lkv_pkg::DATA_W-1:0] k,
			logic [lkv_pkg::DATA_W-1:0] v);
		int gap;
		gap = draw_gap(src_idle);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.func  <= op;
		req_ch.key   <= k;
		req_ch.value <= v;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	// Hold off requests until every outstanding response has come back
	task automatic wait_responses_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (lookup_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
		wait_responses_drained();
		@(negedge clk);
		cfg_ch.valid    <= 1'b1;
		cfg_ch.capacity <= cap;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_edge_keys();
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0005, 32'h1234_5678);
		send_request(lkv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lkv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lkv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		// Stored -1 must come back with hit set
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(lkv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
		send_request(lkv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'hAAAA_5555);
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);
	endtask

	// Capacity of one, then zero, while four entries are still resident
	task automatic test_tiny_capacity();
		write_capacity(5'd1);
		send_request(lkv_pkg::FUNC_PUT, 32'h0000_0011, 32'h0000_0101);
		send_request(lkv_pkg::FUNC_PUT, 32'h0000_0022, 32'h0000_0202);
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0011, 32'h0000_0000);
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0022, 32'h0000_0000);
		write_capacity(5'd0);
		send_request(lkv_pkg::FUNC_PUT, 32'h0000_0033, 32'h0000_0303);
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0022, 32'h0000_0000);
		send_request(lkv_pkg::FUNC_GET, 32'h0000_0033, 32'h0000_0000);
	endtask

	task automatic run_random_phase(logic [lkv_pkg::CAP_W-1:0] cap, int n, bit pause_midway);
		int pool_size;
		logic [lkv_pkg::DATA_W-1:0] k;
		lkv_pkg::func_t op;
		write_capacity(cap);
		pool_size = ((cap == 0) ? 1 : (cap > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : cap)
			+ $urandom_range(1, 8);
		key_pool.delete();
		repeat (pool_size) key_pool.insert(key_pool.size(), $urandom);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				wait_responses_drained();
			op = ($urandom_range(0, 1) == 1) ? lkv_pkg::FUNC_PUT : lkv_pkg::FUNC_GET;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				k = $urandom;
			send_request(op, k, $urandom);
		end
	endtask

	task automatic test_random_traffic();
		logic [lkv_pkg::CAP_W-1:0] caps[11];
		caps = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd2, 5'd7, 5'd17, 5'd12, 5'd3, 5'd9, 5'd16};
		for (int p = 0; p < 11; p++) begin
			// Rotate through no idling, sender only, receiver only, both
			src_idle = (p % 4 == 1) || (p % 4 == 3);
			snk_idle = (p % 4 == 2) || (p % 4 == 3);
			if (p >= 8)
				caps[p] = lkv_pkg::CAP_W'($urandom_range(0, 31));
			run_random_phase(caps[p], PHASE_ITEMS, p == 5);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.func     = lkv_pkg::FUNC_GET;
		req_ch.key      = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.capacity = 5'd16;
		capacity_reg    = 5'd16;
		shadow_count    = 0;
		for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
			shadow_key[i]   = '0;
			shadow_value[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_age[i]   = 0;
		end
		failures        = 0;
		cycle_count     = 0;
		request_count   = 0;
		hit_count       = 0;
		eviction_count  = 0;
		capacity_writes = 0;
		src_idle        = 1'b1;
		snk_idle        = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_edge_keys();
		test_tiny_capacity();
		test_random_traffic();

		wait_responses_drained();
		repeat (8) @(posedge clk);
		if (lookup_answers.size() != 0) begin
			$error("%0d responses never arrived", lookup_answers.size());
			failures++;
		end
		$display("Ran %0d requests: %0d hits, %0d misses, %0d evictions.",
			request_count, hit_count, request_count - hit_count, eviction_count);
		$display("Capacity reprogrammed %0d times, including 0, 1, 16 and 31.", capacity_writes);
		if (failures == 0)
			$display("lru_key_value_cache test passed");
		else
			$display("lru_key_value_cache test failed");
		$finish;
	end

endmodule

FILE: files.f
design/lkv_pkg.sv
design/lkv_intf.sv
design/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_test.sv
